// ===== src/pit_pkg.sv =====
package pit_pkg;

    localparam int WORD_W   = 32;
    localparam int IDX_W    = 16;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = 3;
    localparam int NUM_CFG  = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 64;
    localparam int ACC_W    = 80;

    // particle matrix rows 0..2, element [row*4 + col], col 3 is translation
    typedef struct packed {
        logic [IDX_W-1:0]             idx;
        logic [11:0][WORD_W-1:0]      p;
    } t_pmat;

    // world rows 0..2, element [row*4 + col]
    typedef logic [11:0][WORD_W-1:0] t_world;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v > 80'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -80'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[WORD_W-1:0];
        end
    endfunction

endpackage

// ===== src/pit_front.sv =====
module pit_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [15:0]                i_idx,
    input  logic signed [31:0]         i_pos_x,
    input  logic signed [31:0]         i_pos_y,
    input  logic signed [31:0]         i_pos_z,
    input  logic signed [17:0]         i_quat_w,
    input  logic signed [17:0]         i_quat_x,
    input  logic signed [17:0]         i_quat_y,
    input  logic signed [17:0]         i_quat_z,
    input  logic signed [31:0]         i_scale_x,
    input  logic signed [31:0]         i_scale_y,
    input  logic signed [31:0]         i_scale_z,
    output logic                       o_push,
    output pit_pkg::t_pmat             o_entry
);
    import pit_pkg::*;

    localparam int QW = 36;
    localparam int RW = 40;
    localparam int PW = 72;

    // stage a: quaternion pair products
    logic                    r_a_vld;
    logic [IDX_W-1:0]        r_a_idx;
    logic signed [31:0]      r_a_pos [3];
    logic signed [31:0]      r_a_s   [3];
    logic signed [QW-1:0]    r_a_q   [9];
    logic signed [QW-1:0]    n_a_q   [9];

    // stage b: rotation times scale products
    logic                    r_b_vld;
    logic [IDX_W-1:0]        r_b_idx;
    logic signed [31:0]      r_b_pos [3];
    logic signed [PW-1:0]    r_b_p   [9];
    logic signed [PW-1:0]    n_b_p   [9];

    // xx yy zz xy xz yz wx wy wz
    always_comb begin
        logic signed [QW-1:0] pr [9];
        pr[0] = i_quat_x * i_quat_x;
        pr[1] = i_quat_y * i_quat_y;
        pr[2] = i_quat_z * i_quat_z;
        pr[3] = i_quat_x * i_quat_y;
        pr[4] = i_quat_x * i_quat_z;
        pr[5] = i_quat_y * i_quat_z;
        pr[6] = i_quat_w * i_quat_x;
        pr[7] = i_quat_w * i_quat_y;
        pr[8] = i_quat_w * i_quat_z;
        for (int i = 0; i < 9; i++) begin
            n_a_q[i] = pr[i] >>> FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
        end
        r_a_idx    <= i_idx;
        r_a_pos[0] <= i_pos_x;
        r_a_pos[1] <= i_pos_y;
        r_a_pos[2] <= i_pos_z;
        r_a_s[0]   <= i_scale_x;
        r_a_s[1]   <= i_scale_y;
        r_a_s[2]   <= i_scale_z;
        r_a_q      <= n_a_q;
    end

    always_comb begin
        logic signed [RW-1:0] one;
        logic signed [RW-1:0] rm [9];
        logic signed [RW-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
        one = 40'sd1 <<< FRAC_BITS;
        xx = RW'(r_a_q[0]);
        yy = RW'(r_a_q[1]);
        zz = RW'(r_a_q[2]);
        xy = RW'(r_a_q[3]);
        xz = RW'(r_a_q[4]);
        yz = RW'(r_a_q[5]);
        wx = RW'(r_a_q[6]);
        wy = RW'(r_a_q[7]);
        wz = RW'(r_a_q[8]);
        rm[0] = one - ((yy + zz) <<< 1);
        rm[1] = (xy - wz) <<< 1;
        rm[2] = (xz + wy) <<< 1;
        rm[3] = (xy + wz) <<< 1;
        rm[4] = one - ((xx + zz) <<< 1);
        rm[5] = (yz - wx) <<< 1;
        rm[6] = (xz - wy) <<< 1;
        rm[7] = (yz + wx) <<< 1;
        rm[8] = one - ((xx + yy) <<< 1);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_b_p[r*3+c] = PW'(rm[r*3+c]) * PW'(r_a_s[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_idx <= r_a_idx;
        r_b_pos <= r_a_pos;
        r_b_p   <= n_b_p;
    end

    // shift, clamp and form the queue entry
    always_comb begin
        logic signed [ACC_W-1:0] w;
        o_entry.idx = r_b_idx;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                w = ACC_W'(r_b_p[r*3+c]) >>> FRAC_BITS;
                o_entry.p[r*4+c] = sat32(w);
            end
            o_entry.p[r*4+3] = r_b_pos[r];
        end
    end

    assign o_push = r_b_vld;

endmodule

// ===== src/pit_queue.sv =====
module pit_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pit_pkg::t_pmat    i_din,
    input  logic              i_pop,
    output logic              o_nonempty,
    output pit_pkg::t_pmat    o_head
);
    import pit_pkg::*;

    t_pmat               r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wp, r_rp;
    logic [QCNT_W-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_din;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    assign o_nonempty = (r_cnt != '0);
    assign o_head     = r_mem[r_rp];

endmodule

// ===== src/pit_back.sv =====
module pit_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_nonempty,
    input  pit_pkg::t_pmat        i_head,
    input  pit_pkg::t_world       i_world,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic [15:0]           o_out_index,
    output logic [1:0]            o_row_number,
    output logic signed [31:0]    o_col0,
    output logic signed [31:0]    o_col1,
    output logic signed [31:0]    o_col2,
    output logic signed [31:0]    o_col3,
    output logic                  o_last_row
);
    import pit_pkg::*;

    localparam logic [1:0] LAST_ROW = 2'd2;

    logic [1:0]            r_row;
    logic                  r_m_vld;
    logic [IDX_W-1:0]      r_m_idx;
    logic [1:0]            r_m_row;
    logic signed [63:0]    r_m [12];
    logic signed [63:0]    n_m [12];
    logic signed [31:0]    r_trans;
    logic signed [31:0]    n_col [4];

    assign o_pop = i_nonempty && (r_row == LAST_ROW);

    // one row per cycle while the queue is nonempty: 12 products of world row times particle columns
    always_comb begin
        logic signed [31:0] we, pe;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 3; k++) begin
                we = i_world[{2'(r_row), 2'(k)}];
                pe = i_head.p[k*4+c];
                n_m[c*3+k] = 64'(we) * 64'(pe);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_m_vld <= 1'b0;
        end else begin
            r_m_vld <= i_nonempty;
            if (i_nonempty) begin
                r_row <= (r_row == LAST_ROW) ? 2'd0 : r_row + 2'd1;
            end
        end
        r_m_idx <= i_head.idx;
        r_m_row <= r_row;
        r_m     <= n_m;
        r_trans <= i_world[{r_row, 2'd3}];
    end

    always_comb begin
        logic signed [ACC_W-1:0] acc;
        for (int c = 0; c < 4; c++) begin
            acc = (ACC_W'(r_m[c*3])   >>> FRAC_BITS)
                + (ACC_W'(r_m[c*3+1]) >>> FRAC_BITS)
                + (ACC_W'(r_m[c*3+2]) >>> FRAC_BITS);
            if (c == 3) begin
                acc = acc + ACC_W'(r_trans);
            end
            n_col[c] = sat32(acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_m_vld;
        end
        o_out_index  <= r_m_idx;
        o_row_number <= r_m_row;
        o_col0       <= n_col[0];
        o_col1       <= n_col[1];
        o_col2       <= n_col[2];
        o_col3       <= n_col[3];
        o_last_row   <= (r_m_row == LAST_ROW);
    end

endmodule

// ===== src/particle_instance_transform_top.sv =====
// particle instance transform: world * translate(pos) * rot(quat) * scale
// input: a particle is transferred when start is high and busy is low
// particles whose index is not below MAX_PARTICLES are dropped without results
// front: two stages (quaternion products, rotation times scale) feed a
// four-entry queue of particle matrices
// back: one output row per cycle while the queue is nonempty, multiply stage then sum and clamp stage
// each particle gives three rows (row 0, 1, 2, last_row marks row 2), each on
// the o_ result ports for one cycle with o_valid high; the receiver cannot stall
// a transfer reaches row 0 through stages a and b, the queue, multiply, then sum and clamp;
// rows 1 and 2 follow back to back, and new particles are taken before the last is out;
// busy rises when four particles are in flight between front and back
// config: world rows 0..2 as six 64-bit registers over i_cfg_valid/o_cfg_ready,
// always ready; the user must write them only while idle, the block does not enforce it
// reset (synchronous, active low) empties the pipeline and loads identity
module particle_instance_transform_top #(
    parameter int FRAC_BITS     = 16,
    parameter int MAX_PARTICLES = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [15:0]          i_particle_index,
    input  logic signed [31:0]   i_pos_x,
    input  logic signed [31:0]   i_pos_y,
    input  logic signed [31:0]   i_pos_z,
    input  logic signed [17:0]   i_quat_w,
    input  logic signed [17:0]   i_quat_x,
    input  logic signed [17:0]   i_quat_y,
    input  logic signed [17:0]   i_quat_z,
    input  logic signed [31:0]   i_scale_x,
    input  logic signed [31:0]   i_scale_y,
    input  logic signed [31:0]   i_scale_z,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [pit_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pit_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                 o_valid,
    output logic [15:0]          o_out_index,
    output logic [1:0]           o_row_number,
    output logic signed [31:0]   o_col0,
    output logic signed [31:0]   o_col1,
    output logic signed [31:0]   o_col2,
    output logic signed [31:0]   o_col3,
    output logic                 o_last_row
);
    import pit_pkg::*;

    localparam logic [CFG_W-1:0] ONE = CFG_W'(1) << FRAC_BITS;

    logic [CFG_W-1:0]    r_world [NUM_CFG];
    t_world              world;
    logic [QCNT_W-1:0]   r_cred;
    logic                accept, in_range, push_in;
    logic                q_push, q_pop, q_nonempty;
    t_pmat               q_din, q_head;

    // world registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_world[0] <= ONE;
            r_world[1] <= '0;
            r_world[2] <= ONE << 32;
            r_world[3] <= '0;
            r_world[4] <= '0;
            r_world[5] <= ONE;
        end else if (i_cfg_valid && (32'(i_cfg_index) < NUM_CFG)) begin
            r_world[i_cfg_index] <= i_cfg_data;
        end
    end

    // register i holds row i/2, columns 2*(i%2) and 2*(i%2)+1
    always_comb begin
        for (int i = 0; i < NUM_CFG; i++) begin
            world[i*2]   = r_world[i][31:0];
            world[i*2+1] = r_world[i][63:32];
        end
    end

    // credits cover both front stages and the queue, so the queue never overflows
    assign busy     = (r_cred == QCNT_W'(QDEPTH));
    assign accept   = start && !busy;
    assign in_range = (32'(i_particle_index) < MAX_PARTICLES);
    assign push_in  = accept && in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cred <= '0;
        end else begin
            r_cred <= r_cred + QCNT_W'(push_in) - QCNT_W'(q_pop);
        end
    end

    pit_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (push_in),
        .i_idx     (i_particle_index),
        .i_pos_x   (i_pos_x),
        .i_pos_y   (i_pos_y),
        .i_pos_z   (i_pos_z),
        .i_quat_w  (i_quat_w),
        .i_quat_x  (i_quat_x),
        .i_quat_y  (i_quat_y),
        .i_quat_z  (i_quat_z),
        .i_scale_x (i_scale_x),
        .i_scale_y (i_scale_y),
        .i_scale_z (i_scale_z),
        .o_push    (q_push),
        .o_entry   (q_din)
    );

    pit_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_din      (q_din),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_head     (q_head)
    );

    pit_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_nonempty   (q_nonempty),
        .i_head       (q_head),
        .i_world      (world),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .o_out_index  (o_out_index),
        .o_row_number (o_row_number),
        .o_col0       (o_col0),
        .o_col1       (o_col1),
        .o_col2       (o_col2),
        .o_col3       (o_col3),
        .o_last_row   (o_last_row)
    );

endmodule
